// ===== hw/rtl/calendar_datetime_add_unit_macros.svh =====
// assertion macros shared by the calendar date-time adder modules
`ifndef CALENDAR_DATETIME_ADD_UNIT_MACROS_SVH
`define CALENDAR_DATETIME_ADD_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CAD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cad assertion failed");

// next-cycle implication, disabled during reset
`define CAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cad assertion failed");

`endif

// ===== hw/rtl/cad_pkg.sv =====
// types, constants and helper functions for the calendar date-time adder
package cad_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DATE_W   = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int AYEARS_W = 8;
   localparam int AMONTH_W = 8;
   localparam int ADAYS_W  = 10;
   localparam int AHOURS_W = 10;
   localparam int AMINS_W  = 12;
   localparam int ASECS_W  = 12;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 40;

   // working widths
   localparam int TMP_W   = 14;
   localparam int QUO_W   = 7;
   localparam int REM_W   = 9;
   localparam int DSUM_W  = 11;
   localparam int RECIP_W = 13;
   localparam int PROD_W  = TMP_W + RECIP_W;
   localparam int RECIP_SHIFT = 16;

   localparam int SECS_PER_MIN   = 60;
   localparam int HOURS_PER_DAY  = 24;
   localparam int MONTHS_PER_YR  = 12;
   localparam int LEAP_CYCLE     = 400;
   localparam int CENTURY        = 100;
   localparam int YEAR_MAX       = (1 << YEAR_W) - 1;

   typedef logic [2:0] cad_dst_type;
   localparam cad_dst_type DST_SEC   = 3'd0;
   localparam cad_dst_type DST_MIN   = 3'd1;
   localparam cad_dst_type DST_HOUR  = 3'd2;
   localparam cad_dst_type DST_YEAR  = 3'd3;
   localparam cad_dst_type DST_MONTH = 3'd4;

   typedef struct packed {
      logic        load;
      logic        div_q;
      logic        div_r;
      logic        walk;
      logic        out_load;
      cad_dst_type dst;
   } cad_cmd_type;

   typedef struct packed {
      logic walk_done;
   } cad_status_type;

   typedef struct packed {
      logic [3:0]          pad;
      logic [ASECS_W-1:0]  add_seconds;
      logic [AMINS_W-1:0]  add_minutes;
      logic [AHOURS_W-1:0] add_hours;
      logic [ADAYS_W-1:0]  add_days;
      logic [AMONTH_W-1:0] add_months;
      logic [AYEARS_W-1:0] add_years;
      logic [SECOND_W-1:0] start_second;
      logic [MINUTE_W-1:0] start_minute;
      logic [HOUR_W-1:0]   start_hour;
      logic [DATE_W-1:0]   start_date;
      logic [MONTH_W-1:0]  start_month;
      logic [YEAR_W-1:0]   start_year;
   } cad_req_type;

   typedef struct packed {
      logic [SECOND_W-1:0] new_second;
      logic [MINUTE_W-1:0] new_minute;
      logic [HOUR_W-1:0]   new_hour;
      logic [DATE_W-1:0]   new_date;
      logic [MONTH_W-1:0]  new_month;
      logic [YEAR_W-1:0]   new_year;
   } cad_rsp_type;

   // divisor for each carry step
   function automatic logic [REM_W-1:0] div_const(input cad_dst_type dst);
      logic [REM_W-1:0] d;
      unique case (dst)
         DST_SEC, DST_MIN: d = REM_W'(SECS_PER_MIN);
         DST_HOUR:         d = REM_W'(HOURS_PER_DAY);
         DST_YEAR:         d = REM_W'(LEAP_CYCLE);
         DST_MONTH:        d = REM_W'(MONTHS_PER_YR);
         default:          d = REM_W'(SECS_PER_MIN);
      endcase
      return d;
   endfunction

   // floor(2^16 / divisor), quotient estimate is low by at most one
   function automatic logic [RECIP_W-1:0] div_recip(input cad_dst_type dst);
      logic [RECIP_W-1:0] m;
      unique case (dst)
         DST_SEC, DST_MIN: m = RECIP_W'((1 << RECIP_SHIFT) / SECS_PER_MIN);
         DST_HOUR:         m = RECIP_W'((1 << RECIP_SHIFT) / HOURS_PER_DAY);
         DST_YEAR:         m = RECIP_W'((1 << RECIP_SHIFT) / LEAP_CYCLE);
         DST_MONTH:        m = RECIP_W'((1 << RECIP_SHIFT) / MONTHS_PER_YR);
         default:          m = RECIP_W'((1 << RECIP_SHIFT) / SECS_PER_MIN);
      endcase
      return m;
   endfunction

   function automatic logic [DATE_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
      logic [DATE_W-1:0] n;
      unique case (month)
         4'd2:                   n = leap ? DATE_W'(29) : DATE_W'(28);
         4'd4, 4'd6, 4'd9, 4'd11: n = DATE_W'(30);
         default:                n = DATE_W'(31);
      endcase
      return n;
   endfunction

endpackage

// ===== hw/rtl/cad_ctrl.sv =====
// sequencer for the carry, day-walk and month-add steps plus output valid
module cad_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output cad_pkg::cad_cmd_type    cmd,
   input  cad_pkg::cad_status_type status
);
   import cad_pkg::*;
   `include "calendar_datetime_add_unit_macros.svh"

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SEC_Q = 4'd1;
   localparam logic [3:0] ST_SEC_R = 4'd2;
   localparam logic [3:0] ST_MIN_Q = 4'd3;
   localparam logic [3:0] ST_MIN_R = 4'd4;
   localparam logic [3:0] ST_HR_Q  = 4'd5;
   localparam logic [3:0] ST_HR_R  = 4'd6;
   localparam logic [3:0] ST_YR_Q  = 4'd7;
   localparam logic [3:0] ST_YR_R  = 4'd8;
   localparam logic [3:0] ST_WALK  = 4'd9;
   localparam logic [3:0] ST_MON_Q = 4'd10;
   localparam logic [3:0] ST_MON_R = 4'd11;
   localparam logic [3:0] ST_DONE  = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.dst  = DST_SEC;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = accept;
            if (accept) state_in = ST_SEC_Q;
         end
         ST_SEC_Q: begin cmd.div_q = 1'b1; cmd.dst = DST_SEC;   state_in = ST_SEC_R; end
         ST_SEC_R: begin cmd.div_r = 1'b1; cmd.dst = DST_SEC;   state_in = ST_MIN_Q; end
         ST_MIN_Q: begin cmd.div_q = 1'b1; cmd.dst = DST_MIN;   state_in = ST_MIN_R; end
         ST_MIN_R: begin cmd.div_r = 1'b1; cmd.dst = DST_MIN;   state_in = ST_HR_Q;  end
         ST_HR_Q:  begin cmd.div_q = 1'b1; cmd.dst = DST_HOUR;  state_in = ST_HR_R;  end
         ST_HR_R:  begin cmd.div_r = 1'b1; cmd.dst = DST_HOUR;  state_in = ST_YR_Q;  end
         ST_YR_Q:  begin cmd.div_q = 1'b1; cmd.dst = DST_YEAR;  state_in = ST_YR_R;  end
         ST_YR_R:  begin cmd.div_r = 1'b1; cmd.dst = DST_YEAR;  state_in = ST_WALK;  end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_done) state_in = ST_MON_Q;
         end
         ST_MON_Q: begin cmd.div_q = 1'b1; cmd.dst = DST_MONTH; state_in = ST_MON_R; end
         ST_MON_R: begin cmd.div_r = 1'b1; cmd.dst = DST_MONTH; state_in = ST_DONE;  end
         ST_DONE: begin
            cmd.out_load = out_free;
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_tready)       rsp_valid_in = 1'b0;
      else                       rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `CAD_ASSERT_NOW(a_out_load_free, clock, reset, cmd.out_load, !rsp_valid_ff || rsp_tready)
   `CAD_ASSERT_NEXT(a_accept_starts, clock, reset, req_tvalid && req_tready, state_ff == ST_SEC_Q)
   `CAD_ASSERT_NEXT(a_walk_holds, clock, reset, state_ff == ST_WALK && !status.walk_done, state_ff == ST_WALK)

endmodule

// ===== hw/rtl/cad_dp.sv =====
// datapath: field registers, shared reciprocal divider, day walk and output register
module cad_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [cad_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  cad_pkg::cad_cmd_type                 cmd,
   output cad_pkg::cad_status_type              status,
   output logic [cad_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import cad_pkg::*;
   `include "calendar_datetime_add_unit_macros.svh"

   cad_req_type req_beat;

   logic [YEAR_W-1:0]   year_ff, year_in;
   logic [MONTH_W-1:0]  month_ff, month_in;
   logic [DSUM_W-1:0]   date_ff, date_in;
   logic [HOUR_W-1:0]   hour_ff, hour_in;
   logic [MINUTE_W-1:0] minute_ff, minute_in;
   logic [SECOND_W-1:0] second_ff, second_in;
   logic [AYEARS_W-1:0] a_years_ff, a_years_in;
   logic [AMONTH_W-1:0] a_months_ff, a_months_in;
   logic [ADAYS_W-1:0]  a_days_ff, a_days_in;
   logic [AHOURS_W-1:0] a_hours_ff, a_hours_in;
   logic [AMINS_W-1:0]  a_minutes_ff, a_minutes_in;
   logic [REM_W-1:0]    r400_ff, r400_in;
   logic [TMP_W-1:0]    t_ff, t_in;
   logic [QUO_W-1:0]    q_ff, q_in;
   cad_rsp_type         rsp_ff, rsp_in;

   logic [RECIP_W-1:0]  recip;
   logic [REM_W-1:0]    divisor;
   logic [PROD_W-1:0]   prod;
   logic [15:0]         qd;
   logic [TMP_W-1:0]    r_raw;
   logic [REM_W-1:0]    r_fix;
   logic [QUO_W-1:0]    q_fix;
   logic                leap;
   logic [DATE_W-1:0]   mlen;
   logic                walk_done;
   logic [MONTH_W-1:0]  start_month_sat;

   assign req_beat = req_tdata;

   assign recip   = div_recip(cmd.dst);
   assign divisor = div_const(cmd.dst);
   assign prod    = PROD_W'(t_ff) * PROD_W'(recip);
   assign qd      = 16'(q_ff) * 16'(divisor);
   assign r_raw   = t_ff - qd[TMP_W-1:0];

   always_comb begin
      if (r_raw >= TMP_W'(divisor)) begin
         r_fix = REM_W'(r_raw - TMP_W'(divisor));
         q_fix = q_ff + QUO_W'(1);
      end else begin
         r_fix = REM_W'(r_raw);
         q_fix = q_ff;
      end
   end

   assign leap = (r400_ff[1:0] == 2'd0) && (r400_ff != REM_W'(CENTURY))
              && (r400_ff != REM_W'(2 * CENTURY)) && (r400_ff != REM_W'(3 * CENTURY));
   assign mlen      = month_days(month_ff, leap);
   assign walk_done = (date_ff <= DSUM_W'(mlen));
   assign status.walk_done = walk_done;

   always_comb begin
      priority if (req_beat.start_month == '0)
         start_month_sat = MONTH_W'(1);
      else if (req_beat.start_month > MONTH_W'(MONTHS_PER_YR))
         start_month_sat = MONTH_W'(MONTHS_PER_YR);
      else
         start_month_sat = req_beat.start_month;
   end

   always_comb begin
      year_in      = year_ff;
      month_in     = month_ff;
      date_in      = date_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      second_in    = second_ff;
      a_years_in   = a_years_ff;
      a_months_in  = a_months_ff;
      a_days_in    = a_days_ff;
      a_hours_in   = a_hours_ff;
      a_minutes_in = a_minutes_ff;
      r400_in      = r400_ff;
      t_in         = t_ff;
      q_in         = q_ff;
      rsp_in       = rsp_ff;

      if (cmd.load) begin
         year_in      = req_beat.start_year;
         month_in     = start_month_sat;
         date_in      = DSUM_W'(req_beat.start_date);
         hour_in      = req_beat.start_hour;
         minute_in    = req_beat.start_minute;
         a_years_in   = req_beat.add_years;
         a_months_in  = req_beat.add_months;
         a_days_in    = req_beat.add_days;
         a_hours_in   = req_beat.add_hours;
         a_minutes_in = req_beat.add_minutes;
         t_in = TMP_W'(req_beat.start_second) + TMP_W'(req_beat.add_seconds);
      end

      if (cmd.div_q) q_in = prod[RECIP_SHIFT +: QUO_W];

      if (cmd.div_r) begin
         unique case (cmd.dst)
            DST_SEC: begin
               second_in = SECOND_W'(r_fix);
               t_in = TMP_W'(minute_ff) + TMP_W'(a_minutes_ff) + TMP_W'(q_fix);
            end
            DST_MIN: begin
               minute_in = MINUTE_W'(r_fix);
               t_in = TMP_W'(hour_ff) + TMP_W'(a_hours_ff) + TMP_W'(q_fix);
            end
            DST_HOUR: begin
               hour_in = HOUR_W'(r_fix);
               date_in = date_ff + DSUM_W'(a_days_ff) + DSUM_W'(q_fix);
               t_in    = year_ff;
            end
            DST_YEAR: r400_in = r_fix;
            DST_MONTH: begin
               month_in = MONTH_W'(r_fix) + MONTH_W'(1);
               year_in  = year_ff + YEAR_W'(q_fix) + YEAR_W'(a_years_ff);
            end
            default: q_in = q_ff;
         endcase
      end

      if (cmd.walk) begin
         if (!walk_done) begin
            date_in = date_ff - DSUM_W'(mlen);
            if (month_ff == MONTH_W'(MONTHS_PER_YR)) begin
               month_in = MONTH_W'(1);
               year_in  = year_ff + YEAR_W'(1);
               if (year_ff == YEAR_W'(YEAR_MAX) || r400_ff == REM_W'(LEAP_CYCLE - 1))
                  r400_in = '0;
               else
                  r400_in = r400_ff + REM_W'(1);
            end else begin
               month_in = month_ff + MONTH_W'(1);
            end
         end else begin
            t_in = TMP_W'(month_ff) - TMP_W'(1) + TMP_W'(a_months_ff);
         end
      end

      if (cmd.out_load) begin
         rsp_in.new_year   = year_ff;
         rsp_in.new_month  = month_ff;
         rsp_in.new_date   = DATE_W'(date_ff);
         rsp_in.new_hour   = hour_ff;
         rsp_in.new_minute = minute_ff;
         rsp_in.new_second = second_ff;
      end
   end

   always_ff @(posedge clock) begin
      year_ff      <= year_in;
      month_ff     <= month_in;
      date_ff      <= date_in;
      hour_ff      <= hour_in;
      minute_ff    <= minute_in;
      second_ff    <= second_in;
      a_years_ff   <= a_years_in;
      a_months_ff  <= a_months_in;
      a_days_ff    <= a_days_in;
      a_hours_ff   <= a_hours_in;
      a_minutes_ff <= a_minutes_in;
      r400_ff      <= r400_in;
      t_ff         <= t_in;
      q_ff         <= q_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_tdata = rsp_ff;

   `CAD_ASSERT_NOW(a_walk_month_ok, clock, reset, cmd.walk, month_ff >= 4'd1 && month_ff <= 4'd12)
   `CAD_ASSERT_NOW(a_walk_date_fits, clock, reset, cmd.walk && walk_done, date_ff <= 11'd31)
   `CAD_ASSERT_NEXT(a_r400_range, clock, reset, cmd.div_r && cmd.dst == DST_YEAR, r400_ff <= 9'd399)

endmodule

// ===== hw/rtl/calendar_datetime_add_unit.sv =====
// top level of the calendar date-time adder: controller plus datapath
// a request beat is taken only in idle; the sequencer then runs the second, minute, hour and year
//   divide steps, the day walk (0 to 36 months, one month per cycle), the month divide steps
//   and a done state that waits for a free output register before rsp_tvalid is raised;
//   a finished result waits in the output register while the next request is taken
// reset: synchronous active-high reset clears the sequencer state and the output valid
module calendar_datetime_add_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // start_year, start_month, start_date, start_hour, start_minute, start_second,
   // add_years, add_months, add_days, add_hours, add_minutes, add_seconds, 4 zero bits
   input  logic [cad_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // new_year, new_month, new_date, new_hour, new_minute, new_second
   output logic [cad_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import cad_pkg::*;

   cad_cmd_type    cmd;
   cad_status_type status;

   cad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   cad_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule
